/* rtl/core/irx_pkg.sv */
// Shared types and constants for the IR instruction executor.
// Used by irx_divider and ir_instruction_executor_unit; no dependencies.
package irx_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 5;
  localparam int KIND_W    = 2;
  localparam int IP_OUT_W  = 12;
  localparam int ERR_W     = 2;
  localparam int CNT_W     = 5;

  localparam int VAR_DEPTH_DEF     = 4096;
  localparam int TEMP_DEPTH_DEF    = 256;
  localparam int PROGRAM_DEPTH_DEF = 4096;

  // Opcodes
  localparam logic [OP_W-1:0] OP_NULL      = 5'd0;
  localparam logic [OP_W-1:0] OP_ALLOC     = 5'd1;
  localparam logic [OP_W-1:0] OP_DEALLOC   = 5'd2;
  localparam logic [OP_W-1:0] OP_ASSIGN    = 5'd3;
  localparam logic [OP_W-1:0] OP_ADD       = 5'd4;
  localparam logic [OP_W-1:0] OP_SUB       = 5'd5;
  localparam logic [OP_W-1:0] OP_MUL       = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV       = 5'd7;
  localparam logic [OP_W-1:0] OP_AND       = 5'd8;
  localparam logic [OP_W-1:0] OP_OR        = 5'd9;
  localparam logic [OP_W-1:0] OP_LT        = 5'd10;
  localparam logic [OP_W-1:0] OP_GT        = 5'd11;
  localparam logic [OP_W-1:0] OP_EQ        = 5'd12;
  localparam logic [OP_W-1:0] OP_INPUT     = 5'd13;
  localparam logic [OP_W-1:0] OP_PRINT     = 5'd14;
  localparam logic [OP_W-1:0] OP_JUMP      = 5'd15;
  localparam logic [OP_W-1:0] OP_JUMPFALSE = 5'd16;
  localparam logic [OP_W-1:0] OP_END       = 5'd17;

  // Operand kinds; any other code reads as an immediate
  localparam logic [KIND_W-1:0] KIND_VAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEMP = 2'd1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_IMM_DST = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV0    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLOT,
    ST_IDXDIV,
    ST_USE,
    ST_RDW,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SLOT_A,
    SLOT_B,
    SLOT_C
  } slot_t;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_VAR,
    TGT_TEMP,
    TGT_PROG
  } tgt_t;

  function automatic logic is_arith(input logic [OP_W-1:0] op);
    return (op >= OP_ADD) && (op <= OP_EQ);
  endfunction

  function automatic logic is_write_op(input logic [OP_W-1:0] op);
    return (op == OP_ASSIGN) || is_arith(op) || (op == OP_INPUT);
  endfunction

endpackage

/* rtl/core/irx_divider.sv */
// Iterative restoring divider, unsigned 32 by 32, one quotient bit per cycle.
// Depends on irx_pkg for widths.
module irx_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [irx_pkg::DATA_W-1:0] dividend,
  input  logic [irx_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [irx_pkg::DATA_W-1:0] quotient,
  output logic [irx_pkg::DATA_W-1:0] remainder
);

  localparam int W = irx_pkg::DATA_W;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [irx_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]               rem_r, rem_nxt;
  logic [W-1:0]               quo_r, quo_nxt;
  logic [W-1:0]               den_r, den_nxt;
  logic [W:0]                 shifted;
  logic [W+1:0]               diff;
  logic                       ge;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = ~diff[W+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {irx_pkg::CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/core/ir_instruction_executor_unit.sv */
// A divide runs its quotient on the shared divider; a halted block goes straight to its
// result beat without executing. A store or jump index taken modulo a non-power-of-two
// depth is reduced by the same divider first. Throughput: one instruction at a time.
// Reset clears the instruction pointer, the halt flag and the sequencer; the
// variable and temp stores are not cleared and need no clearing pass.
module ir_instruction_executor_unit #(
  parameter int VAR_DEPTH     = irx_pkg::VAR_DEPTH_DEF,
  parameter int TEMP_DEPTH    = irx_pkg::TEMP_DEPTH_DEF,
  parameter int PROGRAM_DEPTH = irx_pkg::PROGRAM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // first_number, second_number, third_number, input_value
  input  logic [127:0]  in_tdata,
  // req_type, first_kind, second_kind, third_kind
  input  logic [10:0]   in_tuser,
  input  logic          in_tvalid,
  output logic          in_tready,
  // next_ip, print_value, halted, error_code, zero pad
  output logic [47:0]   out_tdata,
  // print_valid
  output logic          out_tuser,
  output logic          out_tvalid,
  input  logic          out_tready
);

  localparam int W        = irx_pkg::DATA_W;
  localparam int VAR_AW   = $clog2(VAR_DEPTH);
  localparam int TEMP_AW  = $clog2(TEMP_DEPTH);
  localparam int PC_AW    = $clog2(PROGRAM_DEPTH);
  localparam int IDX_W    = (VAR_AW > TEMP_AW) ?
                            ((VAR_AW > PC_AW) ? VAR_AW : PC_AW) :
                            ((TEMP_AW > PC_AW) ? TEMP_AW : PC_AW);
  localparam int IPX_W    = (PC_AW > irx_pkg::IP_OUT_W) ? PC_AW : irx_pkg::IP_OUT_W;
  localparam bit VAR_POW2  = ((VAR_DEPTH & (VAR_DEPTH - 1)) == 0);
  localparam bit TEMP_POW2 = ((TEMP_DEPTH & (TEMP_DEPTH - 1)) == 0);
  localparam bit PROG_POW2 = ((PROGRAM_DEPTH & (PROGRAM_DEPTH - 1)) == 0);

  irx_pkg::state_t state_r, state_nxt;
  irx_pkg::slot_t  slot_r;

  logic [irx_pkg::OP_W-1:0]   op_r;
  logic [irx_pkg::KIND_W-1:0] ka_r, kb_r, kc_r;
  logic [W-1:0]               na_r, nb_r, nc_r, inval_r;
  logic [2:0]                 need_r;
  logic [W-1:0]               va_r, vb_r, vc_r;
  logic [IDX_W-1:0]           idx_r, dst_idx_r;
  logic [W-1:0]               res_r;
  logic                       dz_r;
  logic                       neg_r;
  logic [PC_AW-1:0]           ip_r;
  logic                       halt_r;
  logic                       prv_r;
  logic [W-1:0]               pval_r;
  logic [irx_pkg::ERR_W-1:0]  err_r;

  logic [W-1:0] var_mem  [VAR_DEPTH];
  logic [W-1:0] temp_mem [TEMP_DEPTH];
  logic [W-1:0] var_rd_r, temp_rd_r;

  logic [irx_pkg::OP_W-1:0] in_op;
  logic [2:0]               in_need;
  logic                     accept;

  logic [irx_pkg::KIND_W-1:0] cur_kind;
  logic [W-1:0]               cur_num;
  irx_pkg::tgt_t              cur_tgt;
  logic                       cur_need;
  logic                       cur_pow2;
  logic [IDX_W-1:0]           cur_mask_idx;
  logic [W-1:0]               cur_depth;
  logic                       cur_rd;
  logic                       cur_skip;
  irx_pkg::tgt_t              dst_tgt;

  logic         div_start, div_done;
  logic [W-1:0] div_a, div_b, div_q, div_rem;
  logic [W-1:0] mag_b, mag_c;
  logic         div_zero;
  logic         we_var, we_temp;

  logic [W-1:0]       alu_res;
  logic [2*W-1:0]     mul_full;
  logic [PC_AW-1:0]   ip_inc;
  logic [IPX_W-1:0]   ip_wide;

  // ---------------- input decode ----------------
  assign in_op  = in_tuser[4:0];
  assign accept = in_tvalid && in_tready;

  always_comb begin
    in_need[0] = (in_op == irx_pkg::OP_ASSIGN) || irx_pkg::is_arith(in_op) ||
                 (in_op == irx_pkg::OP_INPUT) || (in_op == irx_pkg::OP_PRINT) ||
                 (in_op == irx_pkg::OP_JUMP) || (in_op == irx_pkg::OP_JUMPFALSE);
    in_need[1] = (in_op == irx_pkg::OP_ASSIGN) || irx_pkg::is_arith(in_op) ||
                 (in_op == irx_pkg::OP_JUMPFALSE);
    in_need[2] = irx_pkg::is_arith(in_op);
  end

  // ---------------- current operand slot ----------------
  always_comb begin
    unique case (slot_r)
      irx_pkg::SLOT_A: begin cur_kind = ka_r; cur_num = na_r; cur_need = need_r[0]; end
      irx_pkg::SLOT_B: begin cur_kind = kb_r; cur_num = nb_r; cur_need = need_r[1]; end
      irx_pkg::SLOT_C: begin cur_kind = kc_r; cur_num = nc_r; cur_need = need_r[2]; end
      default:         begin cur_kind = ka_r; cur_num = na_r; cur_need = 1'b0;      end
    endcase

    // Jump targets ignore the operand kind
    if (slot_r == irx_pkg::SLOT_A &&
        (op_r == irx_pkg::OP_JUMP || op_r == irx_pkg::OP_JUMPFALSE)) begin
      cur_tgt = irx_pkg::TGT_PROG;
    end else if (cur_kind == irx_pkg::KIND_VAR) begin
      cur_tgt = irx_pkg::TGT_VAR;
    end else if (cur_kind == irx_pkg::KIND_TEMP) begin
      cur_tgt = irx_pkg::TGT_TEMP;
    end else begin
      cur_tgt = irx_pkg::TGT_NONE;
    end

    unique case (cur_tgt)
      irx_pkg::TGT_VAR: begin
        cur_pow2     = VAR_POW2;
        cur_depth    = W'(VAR_DEPTH);
        cur_mask_idx = cur_num[IDX_W-1:0] & IDX_W'(VAR_DEPTH - 1);
      end
      irx_pkg::TGT_TEMP: begin
        cur_pow2     = TEMP_POW2;
        cur_depth    = W'(TEMP_DEPTH);
        cur_mask_idx = cur_num[IDX_W-1:0] & IDX_W'(TEMP_DEPTH - 1);
      end
      irx_pkg::TGT_PROG: begin
        cur_pow2     = PROG_POW2;
        cur_depth    = W'(PROGRAM_DEPTH);
        cur_mask_idx = cur_num[IDX_W-1:0] & IDX_W'(PROGRAM_DEPTH - 1);
      end
      default: begin
        cur_pow2     = 1'b1;
        cur_depth    = W'(1);
        cur_mask_idx = '0;
      end
    endcase

    cur_skip = !cur_need || (cur_tgt == irx_pkg::TGT_NONE);
    cur_rd   = ((cur_tgt == irx_pkg::TGT_VAR) || (cur_tgt == irx_pkg::TGT_TEMP)) &&
               ((slot_r != irx_pkg::SLOT_A) || (op_r == irx_pkg::OP_PRINT));

    if (ka_r == irx_pkg::KIND_VAR)       dst_tgt = irx_pkg::TGT_VAR;
    else if (ka_r == irx_pkg::KIND_TEMP) dst_tgt = irx_pkg::TGT_TEMP;
    else                                 dst_tgt = irx_pkg::TGT_NONE;
  end

  // ---------------- arithmetic ----------------
  assign mag_b    = vb_r[W-1] ? (W'(0) - vb_r) : vb_r;
  assign mag_c    = vc_r[W-1] ? (W'(0) - vc_r) : vc_r;
  assign div_zero = (vc_r == '0);
  assign mul_full = vb_r * vc_r;
  assign ip_inc   = (ip_r == PC_AW'(PROGRAM_DEPTH - 1)) ? '0 : ip_r + 1'b1;

  always_comb begin
    unique case (op_r)
      irx_pkg::OP_ADD: alu_res = vb_r + vc_r;
      irx_pkg::OP_SUB: alu_res = vb_r - vc_r;
      irx_pkg::OP_MUL: alu_res = mul_full[W-1:0];
      irx_pkg::OP_AND: alu_res = W'((vb_r != '0) && (vc_r != '0));
      irx_pkg::OP_OR:  alu_res = W'((vb_r != '0) || (vc_r != '0));
      irx_pkg::OP_LT:  alu_res = W'($signed(vb_r) < $signed(vc_r));
      irx_pkg::OP_GT:  alu_res = W'($signed(vc_r) < $signed(vb_r));
      irx_pkg::OP_EQ:  alu_res = W'(vb_r == vc_r);
      default:         alu_res = '0;
    endcase
  end

  irx_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      irx_pkg::ST_IDLE:
        if (in_tvalid) state_nxt = halt_r ? irx_pkg::ST_DONE : irx_pkg::ST_SLOT;
      irx_pkg::ST_SLOT:
        if (cur_skip) begin
          state_nxt = (slot_r == irx_pkg::SLOT_C) ? irx_pkg::ST_EXEC : irx_pkg::ST_SLOT;
        end else begin
          state_nxt = cur_pow2 ? irx_pkg::ST_USE : irx_pkg::ST_IDXDIV;
        end
      irx_pkg::ST_IDXDIV:
        if (div_done) state_nxt = irx_pkg::ST_USE;
      irx_pkg::ST_USE:
        if (cur_rd) begin
          state_nxt = irx_pkg::ST_RDW;
        end else begin
          state_nxt = (slot_r == irx_pkg::SLOT_C) ? irx_pkg::ST_EXEC : irx_pkg::ST_SLOT;
        end
      irx_pkg::ST_RDW:
        state_nxt = (slot_r == irx_pkg::SLOT_C) ? irx_pkg::ST_EXEC : irx_pkg::ST_SLOT;
      irx_pkg::ST_EXEC:
        if (op_r == irx_pkg::OP_DIV && !div_zero) begin
          state_nxt = irx_pkg::ST_DIV;
        end else if (irx_pkg::is_write_op(op_r)) begin
          state_nxt = irx_pkg::ST_WRITE;
        end else begin
          state_nxt = irx_pkg::ST_DONE;
        end
      irx_pkg::ST_DIV:
        if (div_done) state_nxt = irx_pkg::ST_WRITE;
      irx_pkg::ST_WRITE:
        state_nxt = irx_pkg::ST_DONE;
      irx_pkg::ST_DONE:
        if (out_tready) state_nxt = irx_pkg::ST_IDLE;
      default:
        state_nxt = irx_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    div_start  = 1'b0;
    div_a      = cur_num;
    div_b      = cur_depth;
    we_var     = 1'b0;
    we_temp    = 1'b0;
    unique case (state_r)
      irx_pkg::ST_IDLE: in_tready = 1'b1;
      irx_pkg::ST_SLOT: div_start = !cur_skip && !cur_pow2;
      irx_pkg::ST_EXEC: begin
        div_a     = mag_b;
        div_b     = mag_c;
        div_start = (op_r == irx_pkg::OP_DIV) && !div_zero;
      end
      irx_pkg::ST_WRITE: begin
        we_var  = (dst_tgt == irx_pkg::TGT_VAR);
        we_temp = (dst_tgt == irx_pkg::TGT_TEMP);
      end
      irx_pkg::ST_DONE: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irx_pkg::ST_IDLE;
      slot_r  <= irx_pkg::SLOT_A;
      ip_r    <= '0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      priority case (state_r)
        irx_pkg::ST_IDLE: slot_r <= irx_pkg::SLOT_A;
        irx_pkg::ST_SLOT:
          if (cur_skip && slot_r != irx_pkg::SLOT_C) slot_r <= irx_pkg::slot_t'(slot_r + 1'b1);
        irx_pkg::ST_USE:
          if (!cur_rd && slot_r != irx_pkg::SLOT_C) slot_r <= irx_pkg::slot_t'(slot_r + 1'b1);
        irx_pkg::ST_RDW:
          if (slot_r != irx_pkg::SLOT_C) slot_r <= irx_pkg::slot_t'(slot_r + 1'b1);
        irx_pkg::ST_EXEC: begin
          priority if (op_r == irx_pkg::OP_END) begin
            halt_r <= 1'b1;
          end else if (op_r == irx_pkg::OP_JUMP) begin
            ip_r <= dst_idx_r[PC_AW-1:0];
          end else if (op_r == irx_pkg::OP_JUMPFALSE && vb_r == '0) begin
            ip_r <= dst_idx_r[PC_AW-1:0];
          end else begin
            ip_r <= ip_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      irx_pkg::ST_IDLE:
        if (accept) begin
          op_r    <= in_op;
          ka_r    <= in_tuser[6:5];
          kb_r    <= in_tuser[8:7];
          kc_r    <= in_tuser[10:9];
          na_r    <= in_tdata[31:0];
          nb_r    <= in_tdata[63:32];
          nc_r    <= in_tdata[95:64];
          inval_r <= in_tdata[127:96];
          need_r  <= in_need;
          prv_r   <= 1'b0;
          pval_r  <= '0;
          err_r   <= irx_pkg::ERR_NONE;
          dz_r    <= 1'b0;
        end
      irx_pkg::ST_SLOT: begin
        idx_r <= cur_mask_idx;
        // Immediate operand: the number is the value
        if (cur_skip) begin
          unique case (slot_r)
            irx_pkg::SLOT_A: va_r <= cur_num;
            irx_pkg::SLOT_B: vb_r <= cur_num;
            irx_pkg::SLOT_C: vc_r <= cur_num;
            default: ;
          endcase
        end
      end
      irx_pkg::ST_IDXDIV:
        if (div_done) idx_r <= div_rem[IDX_W-1:0];
      irx_pkg::ST_USE:
        if (slot_r == irx_pkg::SLOT_A) dst_idx_r <= idx_r;
      irx_pkg::ST_RDW: begin
        unique case (slot_r)
          irx_pkg::SLOT_A: va_r <= (cur_tgt == irx_pkg::TGT_VAR) ? var_rd_r : temp_rd_r;
          irx_pkg::SLOT_B: vb_r <= (cur_tgt == irx_pkg::TGT_VAR) ? var_rd_r : temp_rd_r;
          irx_pkg::SLOT_C: vc_r <= (cur_tgt == irx_pkg::TGT_VAR) ? var_rd_r : temp_rd_r;
          default: ;
        endcase
      end
      irx_pkg::ST_EXEC: begin
        neg_r <= vb_r[W-1] ^ vc_r[W-1];
        priority if (op_r == irx_pkg::OP_ASSIGN) begin
          res_r <= vb_r;
        end else if (op_r == irx_pkg::OP_INPUT) begin
          res_r <= inval_r;
        end else if (op_r == irx_pkg::OP_DIV) begin
          res_r <= '0;
          dz_r  <= div_zero;
        end else if (op_r == irx_pkg::OP_PRINT) begin
          prv_r  <= 1'b1;
          pval_r <= va_r;
        end else begin
          res_r <= alu_res;
        end
      end
      irx_pkg::ST_DIV:
        if (div_done) res_r <= neg_r ? (W'(0) - div_q) : div_q;
      irx_pkg::ST_WRITE:
        // Immediate destination wins over divide by zero
        priority if (dst_tgt == irx_pkg::TGT_NONE) begin
          err_r <= irx_pkg::ERR_IMM_DST;
        end else if (dz_r) begin
          err_r <= irx_pkg::ERR_DIV0;
        end else begin
          err_r <= irx_pkg::ERR_NONE;
        end
      default: ;
    endcase
  end

  // ---------------- stores ----------------
  always_ff @(posedge clk) begin
    if (we_var) var_mem[dst_idx_r[VAR_AW-1:0]] <= res_r;
    var_rd_r <= var_mem[idx_r[VAR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_temp) temp_mem[dst_idx_r[TEMP_AW-1:0]] <= res_r;
    temp_rd_r <= temp_mem[idx_r[TEMP_AW-1:0]];
  end

  // ---------------- result beat ----------------
  assign ip_wide   = IPX_W'(ip_r);
  assign out_tdata = {1'b0, err_r, halt_r, pval_r, ip_wide[irx_pkg::IP_OUT_W-1:0]};
  assign out_tuser = prv_r;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result beat is pending");

  a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == irx_pkg::ST_IDXDIV || state_r == irx_pkg::ST_DIV))
    else $error("divider finished outside a wait state");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  a_div0_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && err_r == irx_pkg::ERR_DIV0) |-> (op_r == irx_pkg::OP_DIV))
    else $error("divide-by-zero error on a non-divide instruction");

  a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
    ip_r <= PC_AW'(PROGRAM_DEPTH - 1))
    else $error("instruction pointer beyond program depth");

  a_no_write_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (we_var || we_temp) |-> !halt_r)
    else $error("store written after halt");
`endif

endmodule

/* bench/ir_instruction_executor_unit_test.sv */
// Self-checking bench for ir_instruction_executor_unit: directed table, then random programs.
// Each result beat is checked against its typed row or an in-bench model of the IR machine.
// Depends on irx_pkg and the executor RTL only.
module ir_instruction_executor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irx_pkg::*;

  localparam int unsigned VAR_N  = VAR_DEPTH_DEF;
  localparam int unsigned TEMP_N = TEMP_DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_IMM = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ODD = 2'd3;   // reads as an immediate too
  localparam logic [OP_W-1:0] OP_UNKNOWN_TOP = 5'd31;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam int RANDOM_PER_PHASE = 200;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] k1;
    logic [31:0]       n1;
    logic [KIND_W-1:0] k2;
    logic [31:0]       n2;
    logic [KIND_W-1:0] k3;
    logic [31:0]       n3;
    logic [31:0]       inval;
  } insn_t;

  typedef struct packed {
    logic [IP_OUT_W-1:0] ip;
    logic                pv;
    logic [31:0]         pval;
    logic                halt;
    logic [ERR_W-1:0]    err;
  } outcome_t;

  typedef struct packed {
    insn_t    insn;
    logic     typed;
    outcome_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [127:0] in_tdata = '0;
  logic [10:0]  in_tuser = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;

  // machine state as the executor should hold it
  logic [31:0]         var_mem [VAR_N];
  logic [31:0]         temp_mem [TEMP_N];
  bit                  var_set [VAR_N];
  bit                  temp_set [TEMP_N];
  int unsigned         var_used [$];
  int unsigned         temp_used [$];
  logic [IP_OUT_W-1:0] ip_reg = '0;
  logic                halted_reg = 1'b0;

  outcome_t pending_outcomes [$];
  row_t     directed_rows [$];

  int sender_idle_pct = 12;
  int receiver_idle_pct = 61;
  int mismatches = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_prints = 0;
  int n_error_beats = 0;

  ir_instruction_executor_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d beats still pending", pending_outcomes.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] fetch_operand(logic [KIND_W-1:0] k, logic [31:0] n);
    if (k == KIND_VAR) return var_mem[n % VAR_N];
    if (k == KIND_TEMP) return temp_mem[n % TEMP_N];
    return n;
  endfunction

  // Returns 0 when the destination is not a store entry.
  function automatic bit store_operand(logic [KIND_W-1:0] k, logic [31:0] n,
                                       logic [31:0] value);
    int unsigned idx;
    if (k == KIND_VAR) begin
      idx = n % VAR_N;
      var_mem[idx] = value;
      if (!var_set[idx]) begin
        var_set[idx] = 1'b1;
        var_used.push_back(idx);
      end
      return 1'b1;
    end
    if (k == KIND_TEMP) begin
      idx = n % TEMP_N;
      temp_mem[idx] = value;
      if (!temp_set[idx]) begin
        temp_set[idx] = 1'b1;
        temp_used.push_back(idx);
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] quotient_toward_zero(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic outcome_t execute_insn(insn_t i);
    outcome_t    o;
    logic [31:0] a, b, r;
    bit          div_zero;
    o = '0;
    o.ip = ip_reg + 1'b1;
    a = '0;
    b = '0;
    r = '0;
    div_zero = 1'b0;
    if (halted_reg) begin
      o.ip = ip_reg;
    end else begin
      case (i.op)
        OP_ASSIGN: begin
          if (!store_operand(i.k1, i.n1, fetch_operand(i.k2, i.n2))) o.err = ERR_IMM_DST;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_LT, OP_GT, OP_EQ: begin
          a = fetch_operand(i.k2, i.n2);
          b = fetch_operand(i.k3, i.n3);
          case (i.op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
              if (b == 0) div_zero = 1'b1;
              else r = quotient_toward_zero(a, b);
            end
            OP_AND: r = {31'd0, (a != 0) && (b != 0)};
            OP_OR:  r = {31'd0, (a != 0) || (b != 0)};
            OP_LT:  r = {31'd0, $signed(a) < $signed(b)};
            OP_GT:  r = {31'd0, $signed(a) > $signed(b)};
            default: r = {31'd0, a == b};
          endcase
          if (!store_operand(i.k1, i.n1, r)) o.err = ERR_IMM_DST;
          else if (div_zero) o.err = ERR_DIV0;
        end
        OP_INPUT: begin
          if (!store_operand(i.k1, i.n1, i.inval)) o.err = ERR_IMM_DST;
        end
        OP_PRINT: begin
          o.pv = 1'b1;
          o.pval = fetch_operand(i.k1, i.n1);
        end
        OP_JUMP: o.ip = i.n1[IP_OUT_W-1:0];
        OP_JUMPFALSE: begin
          if (fetch_operand(i.k2, i.n2) == 0) o.ip = i.n1[IP_OUT_W-1:0];
        end
        OP_END: begin
          halted_reg = 1'b1;
          o.ip = ip_reg;
        end
        default: ;
      endcase
    end
    ip_reg = o.ip;
    o.halt = halted_reg;
    return o;
  endfunction

  function automatic insn_t mk(logic [OP_W-1:0] op, logic [KIND_W-1:0] k1, logic [31:0] n1,
                               logic [KIND_W-1:0] k2, logic [31:0] n2,
                               logic [KIND_W-1:0] k3, logic [31:0] n3, logic [31:0] inval);
    return '{op: op, k1: k1, n1: n1, k2: k2, n2: n2, k3: k3, n3: n3, inval: inval};
  endfunction

  function automatic outcome_t res(int ip, logic pv, logic [31:0] pval, logic [ERR_W-1:0] err);
    return '{ip: IP_OUT_W'(ip), pv: pv, pval: pval, halt: 1'b0, err: err};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return I32_MIN;
      4: return I32_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Source operands only name entries already written, or immediates.
  task automatic pick_source(output logic [KIND_W-1:0] k, output logic [31:0] n);
    int sel;
    sel = $urandom_range(9);
    n = $urandom;
    if (sel < 4 && var_used.size() != 0) begin
      k = KIND_VAR;
      n = (n & ~(VAR_N - 1)) | var_used[$urandom_range(var_used.size() - 1)];
    end else if (sel < 7 && temp_used.size() != 0) begin
      k = KIND_TEMP;
      n = (n & ~(TEMP_N - 1)) | temp_used[$urandom_range(temp_used.size() - 1)];
    end else begin
      k = KIND_W'($urandom_range(3, 2));
      n = rand_word();
    end
  endtask

  task automatic pick_dest(output logic [KIND_W-1:0] k, output logic [31:0] n);
    int sel;
    sel = $urandom_range(15);
    n = $urandom;
    if (sel == 0) begin
      k = KIND_W'($urandom_range(3, 2));
    end else if (sel <= 8) begin
      k = KIND_VAR;
      n = (n & ~(VAR_N - 1)) | $urandom_range(31);
    end else if (sel <= 13) begin
      k = KIND_TEMP;
      n = (n & ~(TEMP_N - 1)) | $urandom_range(15);
    end else begin
      k = KIND_VAR;
    end
  endtask

  task automatic make_random_insn(output insn_t i);
    int                sel;
    logic [KIND_W-1:0] k;
    logic [31:0]       n;
    pick_source(k, n);
    i.k1 = k;
    i.n1 = n;
    pick_source(k, n);
    i.k2 = k;
    i.n2 = n;
    pick_source(k, n);
    i.k3 = k;
    i.n3 = n;
    i.inval = rand_word();
    sel = $urandom_range(99);
    if (sel < 8) i.op = OP_ASSIGN;
    else if (sel < 40) i.op = OP_W'($urandom_range(OP_EQ, OP_ADD));
    else if (sel < 52) i.op = OP_DIV;
    else if (sel < 62) i.op = OP_INPUT;
    else if (sel < 74) i.op = OP_PRINT;
    else if (sel < 80) i.op = OP_JUMP;
    else if (sel < 86) i.op = OP_JUMPFALSE;
    else if (sel < 92) i.op = OP_W'($urandom_range(OP_DEALLOC, OP_NULL));
    else i.op = OP_W'($urandom_range(OP_UNKNOWN_TOP, OP_END + 1));
    if (i.op == OP_ASSIGN || i.op == OP_INPUT || (i.op >= OP_ADD && i.op <= OP_EQ)) begin
      pick_dest(k, n);
      i.k1 = k;
      i.n1 = n;
    end
    // steer divides toward zero, minus one and the most negative dividend
    if (i.op == OP_DIV) begin
      case ($urandom_range(3))
        0: begin i.k3 = KIND_IMM; i.n3 = 32'd0; end
        1: begin i.k3 = KIND_ODD; i.n3 = 32'hFFFF_FFFF; end
        2: begin i.k2 = KIND_IMM; i.n2 = I32_MIN; end
        default: ;
      endcase
    end
    if (i.op == OP_JUMP || i.op == OP_JUMPFALSE) i.n1 = rand_word();
  endtask

  task automatic send_insn(insn_t i, logic typed, outcome_t want);
    outcome_t got_model;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {i.inval, i.n3, i.n2, i.n1};
    in_tuser  <= {i.k3, i.k2, i.k1, i.op};
    do @(posedge clk); while (!in_tready);
    got_model = execute_insn(i);
    pending_outcomes.push_back(typed ? want : got_model);
    n_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every pending beat is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns beat %0d: %s got %h, expected %h", $time, n_results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("beat with nothing pending, next_ip", 32'(out_tdata[11:0]), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (want.pv) n_prints++;
        if (want.err != ERR_NONE) n_error_beats++;
        if (out_tdata[11:0] != want.ip) report_mismatch("next_ip", 32'(out_tdata[11:0]),
                                                         32'(want.ip));
        if (out_tuser != want.pv) report_mismatch("print_valid", 32'(out_tuser), 32'(want.pv));
        if (out_tdata[43:12] != want.pval) report_mismatch("print_value", out_tdata[43:12],
                                                            want.pval);
        if (out_tdata[44] != want.halt) report_mismatch("halted", 32'(out_tdata[44]),
                                                         32'(want.halt));
        if (out_tdata[46:45] != want.err) report_mismatch("error_code", 32'(out_tdata[46:45]),
                                                           32'(want.err));
        if (out_tdata[47] !== 1'b0) report_mismatch("pad bit", 32'(out_tdata[47]), '0);
      end
    end
  end

  initial begin
    insn_t ins;
    int    n_directed;
    // write extremes, then read them back through every operation
    directed_rows.push_back('{mk(OP_INPUT, KIND_VAR, 0, KIND_IMM, 0, KIND_IMM, 0, I32_MAX),
                              1'b1, res(1, 0, 0, ERR_NONE)});
    directed_rows.push_back('{mk(OP_INPUT, KIND_TEMP, 32'hFFFF_FFFF, KIND_IMM, 0, KIND_IMM, 0,
                                 I32_MIN), 1'b1, res(2, 0, 0, ERR_NONE)});
    directed_rows.push_back('{mk(OP_INPUT, KIND_IMM, 5, KIND_IMM, 0, KIND_IMM, 0, 32'h1234),
                              1'b1, res(3, 0, 0, ERR_IMM_DST)});
    directed_rows.push_back('{mk(OP_ADD, KIND_VAR, 1, KIND_VAR, 0, KIND_IMM, 1, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_PRINT, KIND_VAR, 1, KIND_IMM, 0, KIND_IMM, 0, 0),
                              1'b1, res(5, 1, I32_MIN, ERR_NONE)});
    directed_rows.push_back('{mk(OP_DIV, KIND_VAR, 2, KIND_TEMP, 255, KIND_IMM, 32'hFFFF_FFFF,
                                 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_DIV, KIND_VAR, 3, KIND_VAR, 0, KIND_IMM, 0, 0),
                              1'b1, res(7, 0, 0, ERR_DIV0)});
    directed_rows.push_back('{mk(OP_DIV, KIND_IMM, 9, KIND_VAR, 0, KIND_ODD, 0, 0),
                              1'b1, res(8, 0, 0, ERR_IMM_DST)});
    directed_rows.push_back('{mk(OP_SUB, KIND_TEMP, 3, KIND_IMM, 0, KIND_IMM, I32_MIN, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_MUL, KIND_VAR, 4, KIND_VAR, 0, KIND_VAR, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_AND, KIND_VAR, 5, KIND_VAR, 3, KIND_ODD, 7, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_OR, KIND_VAR, 6, KIND_VAR, 3, KIND_ODD, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_LT, KIND_VAR, 7, KIND_TEMP, 255, KIND_VAR, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_GT, KIND_TEMP, 0, KIND_TEMP, 255, KIND_ODD, I32_MAX, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_EQ, KIND_TEMP, 1, KIND_VAR, 2, KIND_TEMP, 255, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_ASSIGN, KIND_VAR, 32'hFFFF_FFFF, KIND_VAR, 2, KIND_IMM, 0, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_PRINT, KIND_VAR, 32'hFFFF_FFFF, KIND_IMM, 0, KIND_IMM, 0, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_JUMP, KIND_ODD, 32'hFFFF_FFFF, KIND_IMM, 0, KIND_IMM, 0, 0),
                              1'b1, res(4095, 0, 0, ERR_NONE)});
    directed_rows.push_back('{mk(OP_NULL, KIND_IMM, 0, KIND_IMM, 0, KIND_IMM, 0, 0),
                              1'b1, res(0, 0, 0, ERR_NONE)});
    directed_rows.push_back('{mk(OP_ALLOC, KIND_VAR, 0, KIND_IMM, 0, KIND_IMM, 0, 0), 1'b0, '0});
    directed_rows.push_back('{mk(OP_DEALLOC, KIND_VAR, 0, KIND_IMM, 0, KIND_IMM, 0, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_UNKNOWN_TOP, KIND_ODD, 32'hFFFF_FFFF, KIND_ODD, 32'hFFFF_FFFF,
                                 KIND_ODD, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0});
    directed_rows.push_back('{mk(OP_JUMPFALSE, KIND_IMM, 100, KIND_VAR, 3, KIND_IMM, 0, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_JUMPFALSE, KIND_IMM, 5, KIND_IMM, 1, KIND_IMM, 0, 0),
                              1'b0, '0});
    directed_rows.push_back('{mk(OP_ASSIGN, KIND_ODD, 0, KIND_VAR, 0, KIND_IMM, 0, 0),
                              1'b1, res(102, 0, 0, ERR_IMM_DST)});
    n_directed = directed_rows.size();

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      send_insn(directed_rows[r].insn, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 12 : (phase == 1) ? 61 : 0;
      receiver_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 12 : 0;
      repeat (RANDOM_PER_PHASE) begin
        make_random_insn(ins);
        send_insn(ins, 1'b0, '0);
      end
      drain();
    end

    // halt, then confirm everything after it is ignored
    send_insn(mk(OP_END, KIND_IMM, 0, KIND_IMM, 0, KIND_IMM, 0, 0), 1'b0, '0);
    repeat (8) begin
      make_random_insn(ins);
      send_insn(ins, 1'b0, '0);
    end
    drain();
    repeat (60) @(negedge clk);

    $display("Ran %0d instructions (%0d from the table), %0d result beats checked,",
             n_sent, n_directed, n_results);
    $display("%0d print beats, %0d error beats, halt and post-halt behavior; %0d mismatches",
             n_prints, n_error_beats, mismatches);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
